### rtl/plbc_pkg.sv
package plbc_pkg;

    // working width of the crossing arithmetic
    localparam int AW     = 48;
    // cordic datapath
    localparam int CSTEPS = 30;
    localparam int CXW    = 34;

    typedef logic signed [AW-1:0]  t_wide;
    typedef logic signed [CXW-1:0] t_trig;

    // control that travels with one division
    typedef struct packed {
        logic valid;
        logic skip;
    } t_div_ctl;

    localparam t_trig       CORDIC_START = 34'sd652032874;
    localparam t_trig       Q30_ONE      = 34'sd1073741824;
    localparam logic [33:0] PI_Q32       = 34'd13493037705;
    localparam logic [11:0] HALF_TURN    = 12'd2048;

    localparam logic [31:0] ATAN_Q30 [CSTEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

endpackage

### rtl/plbc_cordic.sv
module plbc_cordic
    import plbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [11:0]        i_code,
    input  logic signed [13:0] i_rho,
    output logic               o_valid,
    output t_trig              o_sin,
    output t_trig              o_cos,
    output logic signed [13:0] o_rho
);

    // input stage
    logic               r_in_v;
    logic [11:0]        r_in_b;
    logic               r_in_neg, r_in_zero, r_in_quart;
    logic signed [13:0] r_in_rho;
    logic [11:0]        n_b;
    logic               n_neg;

    always_comb begin
        n_neg = i_code > HALF_TURN;
        n_b   = n_neg ? 12'(13'd4096 - 13'(i_code)) : i_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_b     <= n_b;
        r_in_neg   <= n_neg;
        r_in_zero  <= n_b == 12'd0;
        r_in_quart <= n_b == HALF_TURN;
        r_in_rho   <= i_rho;
    end

    // rotation stages, index 0 holds the start vector
    t_trig              r_x [CSTEPS+1];
    t_trig              r_y [CSTEPS+1];
    t_trig              r_z [CSTEPS+1];
    logic               r_v [CSTEPS+1];
    logic               r_neg [CSTEPS+1];
    logic               r_zero [CSTEPS+1];
    logic               r_quart [CSTEPS+1];
    logic signed [13:0] r_rho [CSTEPS+1];
    logic [45:0]        n_zprod;

    assign n_zprod = 46'(r_in_b) * 46'(PI_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]     <= CORDIC_START;
        r_y[0]     <= '0;
        r_z[0]     <= CXW'((n_zprod + 46'd8192) >> 14);
        r_neg[0]   <= r_in_neg;
        r_zero[0]  <= r_in_zero;
        r_quart[0] <= r_in_quart;
        r_rho[0]   <= r_in_rho;
    end

    for (genvar i = 0; i < CSTEPS; i++) begin : g_step
        t_trig n_x, n_y, n_z;
        always_comb begin
            if (!r_z[i][CXW-1]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - CXW'(ATAN_Q30[i]);
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + CXW'(ATAN_Q30[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[i+1]     <= n_x;
            r_y[i+1]     <= n_y;
            r_z[i+1]     <= n_z;
            r_neg[i+1]   <= r_neg[i];
            r_zero[i+1]  <= r_zero[i];
            r_quart[i+1] <= r_quart[i];
            r_rho[i+1]   <= r_rho[i];
        end
    end

    // exact axis angles and cosine sign
    t_trig n_sin, n_cos;

    always_comb begin
        if (r_zero[CSTEPS]) begin
            n_sin = '0;
            n_cos = r_neg[CSTEPS] ? -Q30_ONE : Q30_ONE;
        end else if (r_quart[CSTEPS]) begin
            n_sin = Q30_ONE;
            n_cos = '0;
        end else begin
            n_sin = r_y[CSTEPS];
            n_cos = r_neg[CSTEPS] ? -r_x[CSTEPS] : r_x[CSTEPS];
        end
    end

    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[CSTEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        o_sin <= n_sin;
        o_cos <= n_cos;
        o_rho <= r_rho[CSTEPS];
    end

    assign o_valid = r_out_v;

endmodule

### rtl/plbc_rdiv.sv
module plbc_rdiv
    import plbc_pkg::*;
#(
    parameter int QB = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_ctl      i_ctl,
    input  logic [AW-1:0] i_num,
    input  logic [AW-1:0] i_den,
    output t_div_ctl      o_ctl,
    output logic [QB-1:0] o_quo,
    output logic          o_exact
);

    t_div_ctl      r_ctl [QB+1];
    logic [AW-1:0] r_rem [QB+1];
    logic [AW-1:0] r_den [QB+1];
    logic [QB-1:0] r_quo [QB+1];

    // entry stage: quotients beyond the field are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0].valid <= i_ctl.valid;
            r_ctl[0].skip  <= i_ctl.skip || (i_num >= (i_den << QB));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    for (genvar j = 0; j < QB; j++) begin : g_bit
        localparam int K = QB - 1 - j;
        logic [AW-1:0] n_sh;
        logic          n_ge;

        assign n_sh = r_den[j] << K;
        assign n_ge = r_rem[j] >= n_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j+1] <= '0;
            end else begin
                r_ctl[j+1] <= r_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j+1] <= n_ge ? r_rem[j] - n_sh : r_rem[j];
            r_den[j+1] <= r_den[j];
            r_quo[j+1] <= r_quo[j] | (QB'(n_ge) << K);
        end
    end

    assign o_ctl   = r_ctl[QB];
    assign o_quo   = r_quo[QB];
    assign o_exact = r_rem[QB] == '0;

endmodule

### rtl/polar_line_border_clipper.sv
// polar line to image border segment. a line rho = x*cos(theta) + y*sin(theta)
// (rho in pixels with 4 fraction bits, theta = angle_code * pi/4096) is crossed
// with the left, top, right and bottom borders in that order; each crossing is
// rounded to nearest, ties to even, kept if it lies on the border and differs
// from the points already kept. o_segment_valid is set when exactly two points
// remain; start and end give the first two kept points, zero where missing.
// a beat is taken on every clock where start is high, busy is always low, and
// the result appears on o_done after a cordic, two setup stages, a restoring
// divider with one quotient bit per stage and two selection stages.
// the result is shown for one cycle only and cannot be held off.
module polar_line_border_clipper
    import plbc_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 320,
    parameter int IMAGE_HEIGHT = 240
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [13:0] i_rho_q4,
    input  logic [11:0]        i_angle_code,
    output logic               o_done,
    output logic               o_segment_valid,
    output logic [2:0]         o_point_count,
    output logic [8:0]         o_start_x,
    output logic [7:0]         o_start_y,
    output logic [8:0]         o_end_x,
    output logic [7:0]         o_end_y
);

    localparam int MAXD = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int CW   = $clog2(MAXD);
    localparam int QB   = CW + 1;

    localparam logic signed [13:0] W_M1 = 14'(IMAGE_WIDTH - 1);
    localparam logic signed [13:0] H_M1 = 14'(IMAGE_HEIGHT - 1);

    // fully pipelined, never stalls
    assign busy = 1'b0;

    // sine and cosine
    logic               c_v;
    t_trig              c_sin, c_cos;
    logic signed [13:0] c_rho;

    plbc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_code  (i_angle_code),
        .i_rho   (i_rho_q4),
        .o_valid (c_v),
        .o_sin   (c_sin),
        .o_cos   (c_cos),
        .o_rho   (c_rho)
    );

    // stage a: scaled rho and the border offsets
    logic  r_a_v;
    t_wide r_a_rn, r_a_pw, r_a_ph, r_a_s, r_a_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_rn <= AW'(c_rho) <<< 26;
        r_a_pw <= AW'(c_cos) * AW'(W_M1);
        r_a_ph <= AW'(c_sin) * AW'(H_M1);
        r_a_s  <= AW'(c_sin);
        r_a_c  <= AW'(c_cos);
    end

    // stage b: positive divisor, numerator biased by half for rounding
    t_wide         n_num [4];
    t_wide         n_den [4];
    t_div_ctl      r_b_ctl [4];
    logic [AW-1:0] r_b_t [4];
    logic [AW-1:0] r_b_d [4];

    always_comb begin
        n_num[0] = r_a_rn;
        n_den[0] = r_a_s;
        n_num[1] = r_a_rn;
        n_den[1] = r_a_c;
        n_num[2] = r_a_rn - r_a_pw;
        n_den[2] = r_a_s;
        n_num[3] = r_a_rn - r_a_ph;
        n_den[3] = r_a_c;
    end

    for (genvar g = 0; g < 4; g++) begin : g_prep
        t_wide n_nn, n_dd, n_t;
        always_comb begin
            n_nn = n_den[g][AW-1] ? -n_num[g] : n_num[g];
            n_dd = n_den[g][AW-1] ? -n_den[g] : n_den[g];
            n_t  = (n_nn <<< 1) + n_dd;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_ctl[g] <= '0;
            end else begin
                r_b_ctl[g].valid <= r_a_v;
                // zero divisor skips the border; a negative quotient is off it
                r_b_ctl[g].skip  <= (n_dd == '0) || n_t[AW-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_b_t[g] <= n_t;
            r_b_d[g] <= n_dd << 1;
        end
    end

    // dividers, one per border
    t_div_ctl      d_ctl [4];
    logic [QB-1:0] d_quo [4];
    logic          d_exact [4];

    for (genvar g = 0; g < 4; g++) begin : g_div
        plbc_rdiv #(.QB(QB)) u_rdiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (r_b_ctl[g]),
            .i_num   (r_b_t[g]),
            .i_den   (r_b_d[g]),
            .o_ctl   (d_ctl[g]),
            .o_quo   (d_quo[g]),
            .o_exact (d_exact[g])
        );
    end

    // stage c: tie to even, range check, candidate points
    logic          r_c_v;
    logic          r_c_ok [4];
    logic [CW-1:0] r_c_x [4];
    logic [CW-1:0] r_c_y [4];
    logic [QB-1:0] n_r [4];

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            n_r[g] = d_quo[g] - QB'(d_exact[g] & d_quo[g][0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= d_ctl[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // left and right borders give a row, top and bottom a column
        r_c_ok[0] <= !d_ctl[0].skip && (n_r[0] < QB'(IMAGE_HEIGHT));
        r_c_ok[1] <= !d_ctl[1].skip && (n_r[1] < QB'(IMAGE_WIDTH));
        r_c_ok[2] <= !d_ctl[2].skip && (n_r[2] < QB'(IMAGE_HEIGHT));
        r_c_ok[3] <= !d_ctl[3].skip && (n_r[3] < QB'(IMAGE_WIDTH));
        r_c_x[0]  <= '0;
        r_c_y[0]  <= CW'(n_r[0]);
        r_c_x[1]  <= CW'(n_r[1]);
        r_c_y[1]  <= '0;
        r_c_x[2]  <= CW'(IMAGE_WIDTH - 1);
        r_c_y[2]  <= CW'(n_r[2]);
        r_c_x[3]  <= CW'(n_r[3]);
        r_c_y[3]  <= CW'(IMAGE_HEIGHT - 1);
    end

    // stage d: drop repeated points in border order
    logic [2:0]    n_cnt;
    logic [CW-1:0] n_kx [4];
    logic [CW-1:0] n_ky [4];
    logic          n_dup;

    always_comb begin
        n_cnt = '0;
        n_dup = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n_kx[k] = '0;
            n_ky[k] = '0;
        end
        for (int k = 0; k < 4; k++) begin
            n_dup = 1'b0;
            for (int j = 0; j < 4; j++) begin
                if (3'(j) < n_cnt && n_kx[j] == r_c_x[k] && n_ky[j] == r_c_y[k]) begin
                    n_dup = 1'b1;
                end
            end
            if (r_c_ok[k] && !n_dup) begin
                n_kx[n_cnt[1:0]] = r_c_x[k];
                n_ky[n_cnt[1:0]] = r_c_y[k];
                n_cnt = n_cnt + 3'd1;
            end
        end
    end

    logic r_d_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
    end

    // result beat, coordinates masked to the field widths
    always_ff @(posedge i_clk) begin
        o_segment_valid <= n_cnt == 3'd2;
        o_point_count   <= n_cnt;
        o_start_x       <= 9'(n_kx[0]);
        o_start_y       <= 8'(n_ky[0]);
        o_end_x         <= 9'(n_kx[1]);
        o_end_y         <= 8'(n_ky[1]);
    end

    assign o_done = r_d_v;

endmodule

### rtl/plbc_checker.sv
module plbc_checker #(
    parameter int IMAGE_WIDTH  = 320,
    parameter int IMAGE_HEIGHT = 240
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_segment_valid,
    input logic [2:0] o_point_count,
    input logic [8:0] o_start_x,
    input logic [7:0] o_start_y,
    input logic [8:0] o_end_x,
    input logic [7:0] o_end_y
);

    localparam int MAXD = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int LAT  = 38 + $clog2(MAXD) + 1;

    // every accepted beat yields one result at the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result missing at fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without an accepted beat");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_segment_valid == (o_point_count == 3'd2)) && (o_point_count <= 3'd4))
        else $error("segment flag disagrees with point count");

    a_empty_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_point_count < 3'd2) |->
            (o_end_x == 9'd0) && (o_end_y == 8'd0) &&
            ((o_point_count != 3'd0) || ((o_start_x == 9'd0) && (o_start_y == 8'd0))))
        else $error("missing point not cleared");

endmodule

bind polar_line_border_clipper plbc_checker #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_plbc_checker (.*);

### verif/tb_top.sv
module tb_top;
    import plbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_W   = 320;
    localparam int IMG_H   = 240;
    localparam int LATENCY = 48;
    localparam int N_RAND  = 1430;

    // one predicted border segment
    typedef struct {
        logic       seg_valid;
        logic [2:0] n_points;
        logic [8:0] sx;
        logic [7:0] sy;
        logic [8:0] ex;
        logic [7:0] ey;
    } t_segment;

    // arctangent steps of the rotation, in Q30
    localparam longint ROT_ATAN [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2
    };

    // scoreboard: predicts the segment for each line and checks results in order
    class t_scoreboard;
        t_segment pending[$];
        int       n_fail;
        int       n_checked;
        int       n_valid;

        function automatic void rotate(input logic [11:0] code, output longint s,
                                       output longint c);
            longint   x, y, z, nx;
            bit       flip;
            int       b;
            b    = code;
            flip = 0;
            if (b > 2048) begin
                b    = 4096 - b;
                flip = 1;
            end
            if (b == 0) begin
                s = 0;
                c = flip ? -64'sd1073741824 : 64'sd1073741824;
                return;
            end
            if (b == 2048) begin
                s = 1073741824;
                c = 0;
                return;
            end
            z = longint'((longint'(b) * 64'd13493037705 + 8192) >>> 14);
            x = 652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ROT_ATAN[i];
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ROT_ATAN[i];
                end
                x = nx;
            end
            s = y;
            c = flip ? -x : x;
        endfunction

        // rounded quotient, ties to even
        function automatic longint quot_even(input longint num, input longint den);
            longint q, r;
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            q = num / den;
            r = num % den;
            if (r < 0) begin
                q -= 1;
                r += den;
            end
            if (2 * r > den || (2 * r == den && q[0]))
                q += 1;
            return q;
        endfunction

        function automatic void add_point(input longint px, input longint py,
                                          ref longint kx[4], ref longint ky[4],
                                          ref int n);
            if (px < 0 || px >= IMG_W || py < 0 || py >= IMG_H)
                return;
            for (int i = 0; i < n; i++)
                if (kx[i] == px && ky[i] == py)
                    return;
            if (n < 4) begin
                kx[n] = px;
                ky[n] = py;
                n++;
            end
        endfunction

        function void note_line(input logic signed [13:0] rho, input logic [11:0] code);
            longint   s, c, rn;
            longint   kx[4], ky[4];
            int       n;
            t_segment e;
            kx = '{0, 0, 0, 0};
            ky = '{0, 0, 0, 0};
            n  = 0;
            rotate(code, s, c);
            rn = longint'(rho) * 67108864;
            if (s != 0)
                add_point(0, quot_even(rn, s), kx, ky, n);
            if (c != 0)
                add_point(quot_even(rn, c), 0, kx, ky, n);
            if (s != 0)
                add_point(IMG_W - 1, quot_even(rn - (IMG_W - 1) * c, s), kx, ky, n);
            if (c != 0)
                add_point(quot_even(rn - (IMG_H - 1) * s, c), IMG_H - 1, kx, ky, n);
            e.seg_valid = (n == 2);
            e.n_points  = n[2:0];
            e.sx        = kx[0][8:0];
            e.sy        = ky[0][7:0];
            e.ex        = kx[1][8:0];
            e.ey        = ky[1][7:0];
            pending.insert(pending.size(), e);
        endfunction

        function void check_segment(input t_segment got);
            t_segment e;
            if (pending.size() == 0) begin
                $error("result with no line outstanding");
                n_fail++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (e.seg_valid) n_valid++;
            if (got.seg_valid !== e.seg_valid) begin
                $error("segment_valid exp %0d got %0d", e.seg_valid, got.seg_valid);
                n_fail++;
            end
            if (got.n_points !== e.n_points) begin
                $error("point_count exp %0d got %0d", e.n_points, got.n_points);
                n_fail++;
            end
            if (got.sx !== e.sx) begin
                $error("start_x exp %0d got %0d", e.sx, got.sx);
                n_fail++;
            end
            if (got.sy !== e.sy) begin
                $error("start_y exp %0d got %0d", e.sy, got.sy);
                n_fail++;
            end
            if (got.ex !== e.ex) begin
                $error("end_x exp %0d got %0d", e.ex, got.ex);
                n_fail++;
            end
            if (got.ey !== e.ey) begin
                $error("end_y exp %0d got %0d", e.ey, got.ey);
                n_fail++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [13:0] i_rho_q4 = '0;
    logic [11:0]        i_angle_code = '0;
    logic               o_done;
    logic               o_segment_valid;
    logic [2:0]         o_point_count;
    logic [8:0]         o_start_x;
    logic [7:0]         o_start_y;
    logic [8:0]         o_end_x;
    logic [7:0]         o_end_y;

    t_scoreboard board = new();
    int          beat_no = 0;

    always #1 i_clk = ~i_clk;

    polar_line_border_clipper #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_rho_q4        (i_rho_q4),
        .i_angle_code    (i_angle_code),
        .o_done          (o_done),
        .o_segment_valid (o_segment_valid),
        .o_point_count   (o_point_count),
        .o_start_x       (o_start_x),
        .o_start_y       (o_start_y),
        .o_end_x         (o_end_x),
        .o_end_y         (o_end_y)
    );

    // result side: sampled at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        t_segment got;
        if (i_rst_n && o_done) begin
            got.seg_valid = o_segment_valid;
            got.n_points  = o_point_count;
            got.sx        = o_start_x;
            got.sy        = o_start_y;
            got.ex        = o_end_x;
            got.ey        = o_end_y;
            board.check_segment(got);
        end
    end

    // present one line and hold it until the beat is taken; start stays high
    // across back-to-back beats, and random gaps drop it in between
    task automatic send_line(input logic signed [13:0] rho, input logic [11:0] code,
                             input bit may_gap);
        if (may_gap && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_rho_q4     <= rho;
        i_angle_code <= code;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_line(rho, code);
        beat_no++;
    endtask

    // mostly lines that cross the image: rho up to the diagonal, all angles
    task automatic random_line(output logic signed [13:0] rho, output logic [11:0] code);
        int pick;
        pick = $urandom_range(99);
        code = 12'($urandom());
        if (pick < 70) begin
            rho = 14'($urandom_range(0, 400 * 16) - ((code > 2048) ? 200 * 16 : 0));
        end else if (pick < 80) begin
            // near multiples of pi/16, among them the axes and diagonals, where zero divisors and corners live
            code = 12'(($urandom_range(0, 15) << 8) + $urandom_range(0, 2) - 1);
            rho  = 14'($urandom_range(0, 320 * 16));
        end else begin
            rho = 14'($urandom());
        end
    endtask

    initial begin
        logic signed [13:0] r;
        logic [11:0]        a;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, axis angles (zero divisors), corners
        send_line(14'sd0, 12'd0, 0);
        send_line(14'sd0, 12'd2048, 0);
        send_line(14'sd0, 12'd1024, 0);
        send_line(14'sd0, 12'd4095, 0);
        send_line(14'sh2000, 12'd0, 0);
        send_line(14'sd8191, 12'd0, 0);
        send_line(14'sd8191, 12'd4095, 0);
        send_line(14'sh2000, 12'd2048, 0);
        send_line(14'sd1600, 12'd0, 0);
        send_line(14'sd1600, 12'd2048, 0);
        send_line(14'sd5104, 12'd0, 0);
        send_line(14'sd3824, 12'd2048, 0);
        send_line(-14'sd1600, 12'd4095, 0);
        send_line(14'sd2048, 12'd1024, 0);
        send_line(14'sd6096, 12'd1024, 0);
        send_line(-14'sd2048, 12'd3072, 0);
        send_line(14'sd8, 12'd2049, 0);
        send_line(14'sd8, 12'd2047, 0);
        send_line(14'sd2730, 12'd1, 0);
        send_line(-14'sd1, 12'd3000, 0);
        send_line(14'sd4000, 12'd1365, 0);
        send_line(14'sd3000, 12'd2730, 0);

        // random, with a long stretch of back-to-back beats in the middle
        for (int i = 0; i < N_RAND; i++) begin
            random_line(r, a);
            send_line(r, a, !(i > 500 && i < 800));
        end
        start <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("%0d lines sent, %0d results checked, %0d gave a valid segment",
                 beat_no, board.n_checked, board.n_valid);
        if (board.n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

endmodule
